/* sv/modular_exponentiation_unit_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MEU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MEU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/meu_pkg.sv */
// ----------------------------------------------------------------------------
// meu_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package meu_pkg;

    localparam int MSG_BITS       = 8;
    localparam int EXP_BITS       = 32;
    localparam int CIPHER_BITS    = 64;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 1;
    localparam int EXP_IDX_BITS   = $clog2(EXP_BITS);
    localparam int MSG_CNT_BITS   = $clog2(MSG_BITS);

    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b1;

    // commands from the controller
    typedef struct packed {
        logic load;       // capture request byte, init accumulators
        logic red_step;   // one shift-subtract step of byte mod modulus
        logic mul_start;  // launch one modular multiplication
        logic mul_sqr;    // 1: acc*acc, 0: acc*base
        logic exp_shift;  // advance the exponent scan by one bit
        logic out_load;   // write the result register
    } ctrl_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic m_zero;     // modulus is zero
        logic e_le1;      // exponent is 0 or 1
        logic red_last;   // last reduction step in progress
        logic e_bit;      // current exponent bit
        logic e_last;     // current exponent bit is bit 0
        logic mul_done;   // multiplication finished, acc updated this edge
        logic out_free;   // result register can take a new value
    } dp_status_t;

endpackage

/* sv/meu_mulmod.sv */
// ----------------------------------------------------------------------------
// meu_mulmod
// Bit-serial modular multiplier: product = op_a * op_b mod modulus,
// one bit of op_b per cycle, MSB first (double, add, reduce by m or 2m).
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_core_macros.svh"

module meu_mulmod #(
    parameter int MODULUS_BITS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [MODULUS_BITS-1:0] op_a,
    input  logic [MODULUS_BITS-1:0] op_b,
    input  logic [MODULUS_BITS-1:0] modulus,
    output logic                    done,
    output logic [MODULUS_BITS-1:0] product
);

    localparam int CNT_BITS = $clog2(MODULUS_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MODULUS_BITS - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [MODULUS_BITS-1:0] a_reg;
    logic [MODULUS_BITS-1:0] b_reg;
    logic [MODULUS_BITS-1:0] p_reg;
    logic [MODULUS_BITS-1:0] p_next;

    logic [MODULUS_BITS+1:0] sum;
    logic [MODULUS_BITS+1:0] m1;
    logic [MODULUS_BITS+1:0] m2;
    logic [MODULUS_BITS+1:0] red;

    // sum = 2p + bit*a < 3m
    always_comb begin
        m1  = {2'b00, modulus};
        m2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, p_reg, 1'b0}
            + {2'b00, (b_reg[MODULUS_BITS-1] ? a_reg : {MODULUS_BITS{1'b0}})};
        if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
        p_next = red[MODULUS_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
            p_reg <= '0;
        end else if (busy_reg) begin
            p_reg <= p_next;
            b_reg <= {b_reg[MODULUS_BITS-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

    `MEU_ASSERT_SAME(a_done_after_busy, aclk, aresetn, done_reg, $past(busy_reg), "done without a running multiplication")
    `MEU_ASSERT_SAME(a_no_start_busy, aclk, aresetn, start, !busy_reg, "multiplication started while busy")
    `MEU_ASSERT_NEXT(a_done_single, aclk, aresetn, done_reg, !done_reg, "done held longer than one cycle")

endmodule

/* sv/meu_ctrl.sv */
// ----------------------------------------------------------------------------
// meu_ctrl
// Sequencer: byte reduction, left-to-right square-and-multiply, result write.
// ----------------------------------------------------------------------------
module meu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  meu_pkg::dp_status_t status,
    output meu_pkg::ctrl_cmd_t  cmd
);
    import meu_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SQR    = 3'd3;
    localparam logic [2:0] ST_CHKMUL = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       started_reg;
    logic       started_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        started_next = started_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load     = 1'b1;
                    started_next = 1'b0;
                    state_next   = status.m_zero ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.red_step = 1'b1;
                if (status.red_last) begin
                    state_next = status.e_le1 ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (started_reg) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sqr   = 1'b1;
                    state_next    = ST_SQR;
                end else if (status.e_bit) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    // skip leading zero bits
                    cmd.exp_shift = 1'b1;
                    state_next    = status.e_last ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SQR: begin
                if (status.mul_done) begin
                    state_next = ST_CHKMUL;
                end
            end
            ST_CHKMUL: begin
                if (status.e_bit) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    cmd.exp_shift = 1'b1;
                    state_next    = status.e_last ? ST_FINISH : ST_SCAN;
                end
            end
            ST_MUL: begin
                if (status.mul_done) begin
                    started_next  = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = status.e_last ? ST_FINISH : ST_SCAN;
                end
            end
            ST_FINISH: begin
                // hold until the result register frees up
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

/* sv/meu_datapath.sv */
// ----------------------------------------------------------------------------
// meu_datapath
// Configuration registers, byte reduction, exponent scan, accumulator,
// modular multiplier and result register.
// ----------------------------------------------------------------------------
module meu_datapath #(
    parameter int MODULUS_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [meu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [meu_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic [meu_pkg::MSG_BITS-1:0]       s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [meu_pkg::CIPHER_BITS-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser,
    input  meu_pkg::ctrl_cmd_t                 cmd,
    output meu_pkg::dp_status_t                status
);
    import meu_pkg::*;

    localparam logic [MSG_CNT_BITS-1:0] MSG_CNT_LAST = MSG_CNT_BITS'(MSG_BITS - 1);
    localparam logic [EXP_IDX_BITS-1:0] EXP_IDX_LAST = EXP_IDX_BITS'(EXP_BITS - 1);

    logic [EXP_BITS-1:0]     exponent_reg;
    logic [MODULUS_BITS-1:0] modulus_reg;
    logic [MSG_BITS-1:0]     byte_reg;
    logic [MSG_CNT_BITS-1:0] byte_cnt_reg;
    logic [MODULUS_BITS-1:0] base_reg;
    logic [MODULUS_BITS-1:0] base_next;
    logic [MODULUS_BITS-1:0] acc_reg;
    logic [EXP_BITS-1:0]     exp_sh_reg;
    logic [EXP_IDX_BITS-1:0] exp_idx_reg;
    logic [CIPHER_BITS-1:0]  out_data_reg;
    logic                    out_err_reg;
    logic                    out_valid_reg;

    logic [MODULUS_BITS:0]   red_t;
    logic [MODULUS_BITS:0]   red_r;
    logic                    m_zero;
    logic                    e_le1;
    logic                    mm_done;
    logic [MODULUS_BITS-1:0] mm_product;

    assign m_zero = (modulus_reg == '0);
    assign e_le1  = (exponent_reg[EXP_BITS-1:1] == '0);

    // restoring step of byte mod modulus: remainder stays below modulus
    always_comb begin
        red_t = {base_reg, byte_reg[MSG_BITS-1]};
        if (red_t >= {1'b0, modulus_reg}) begin
            red_r = red_t - {1'b0, modulus_reg};
        end else begin
            red_r = red_t;
        end
        base_next = red_r[MODULUS_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= EXP_BITS'(1);
            modulus_reg  <= MODULUS_BITS'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_wr_data[EXP_BITS-1:0];
                REG_MODULUS:  modulus_reg  <= cfg_wr_data[MODULUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg     <= s_axis_tdata;
            byte_cnt_reg <= '0;
            base_reg     <= '0;
            exp_sh_reg   <= exponent_reg;
            exp_idx_reg  <= '0;
        end else begin
            if (cmd.red_step) begin
                base_reg     <= base_next;
                byte_reg     <= {byte_reg[MSG_BITS-2:0], 1'b0};
                byte_cnt_reg <= byte_cnt_reg + 1'b1;
            end
            if (cmd.exp_shift) begin
                exp_sh_reg  <= {exp_sh_reg[EXP_BITS-2:0], 1'b0};
                exp_idx_reg <= exp_idx_reg + 1'b1;
            end
        end
    end

    // acc starts at 1 mod m
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= (modulus_reg == MODULUS_BITS'(1)) ? '0 : MODULUS_BITS'(1);
        end else if (mm_done) begin
            acc_reg <= mm_product;
        end
    end

    meu_mulmod #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (acc_reg),
        .op_b    (cmd.mul_sqr ? acc_reg : base_reg),
        .modulus (modulus_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (m_zero) begin
                out_data_reg <= '0;
            end else if (e_le1) begin
                out_data_reg <= CIPHER_BITS'(base_reg);
            end else begin
                out_data_reg <= CIPHER_BITS'(acc_reg);
            end
            out_err_reg <= m_zero;
        end
    end

    always_comb begin
        status.m_zero   = m_zero;
        status.e_le1    = e_le1;
        status.red_last = (byte_cnt_reg == MSG_CNT_LAST);
        status.e_bit    = exp_sh_reg[EXP_BITS-1];
        status.e_last   = (exp_idx_reg == EXP_IDX_LAST);
        status.mul_done = mm_done;
        status.out_free = !out_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

/* sv/modular_exponentiation_unit_core.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_core
// cipher = message_byte ^ exponent mod modulus (exponent > 0), a request per byte.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata[7:0]  message_byte
//  m_axis   out        tdata[63:0] cipher_value, tuser[0] modulus_error
//  cfg      in         index 0 exponent[31:0], index 1 modulus[63:0]
//
// One request at a time. A byte is first reduced mod the modulus; the exponent
// is then scanned from the top, skipping leading zero bits: the top set bit loads
// the base, each later bit a squaring and, if set, a multiply (bit-serial, one
// multiplier bit per cycle). Exponent 0 or 1 skips the scan and gives the byte
// mod modulus; a zero modulus skips both steps and gives 0 with modulus_error.
// Reset: exponent and modulus return to 1, no request in flight.
// A stalled result waits in the output register; the next request is taken
// meanwhile and its result waits for that register to free up.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_core #(
    parameter int MODULUS_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [meu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [meu_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [meu_pkg::MSG_BITS-1:0]       s_axis_tdata,  // [7:0] message_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [meu_pkg::CIPHER_BITS-1:0]    m_axis_tdata,  // [63:0] cipher_value
    output logic                               m_axis_tuser   // [0] modulus_error
);
    import meu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    meu_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    meu_datapath #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
